// ===== rtl/dpp_pkg.sv =====
// Shared constants and types for the depth pixel to point projector.
`default_nettype none
package dpp_pkg;

  localparam int DefImageWidth  = 256;
  localparam int DefImageHeight = 192;

  localparam int DepthW = 16;
  localparam int PointW = 16;

  localparam int CenterX    = 128;
  localparam int CenterY    = 96;
  localparam int FocalShift = 8;

  localparam logic [DepthW-1:0] FastMinDepth = 16'd615;
  localparam logic [DepthW-1:0] FastMaxDepth = 16'd20480;

  localparam logic [DepthW-1:0] MinDepthRst = 16'd615;
  localparam logic [DepthW-1:0] MaxDepthRst = 16'd20480;

  localparam int FifoDepth = 4;

  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  localparam logic [1:0] RegMode     = 2'd0;
  localparam logic [1:0] RegMinDepth = 2'd1;
  localparam logic [1:0] RegMaxDepth = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [DepthW-1:0] min_depth;
    logic [DepthW-1:0] max_depth;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ===== rtl/dpp_front.sv =====
// Front end: pixel position counters, decimation and depth range classification.
`default_nettype none
module dpp_front #(
  parameter int IMAGE_WIDTH  = dpp_pkg::DefImageWidth,
  parameter int IMAGE_HEIGHT = dpp_pkg::DefImageHeight,
  localparam int ColW = $clog2(IMAGE_WIDTH),
  localparam int RowW = $clog2(IMAGE_HEIGHT)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dpp_pkg::cfg_t             cfg_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [dpp_pkg::DepthW-1:0] depth_i,
  input  wire logic                      depth_invalid_i,
  input  wire logic                      frame_start_i,
  input  wire dpp_pkg::fifo_stat_t       fifo_stat_i,
  output logic                           push_o,
  output logic [ColW-1:0]                col_o,
  output logic [RowW-1:0]                row_o,
  output logic [dpp_pkg::DepthW-1:0]     depth_o
);

  logic [ColW-1:0] col_q, col_d, cur_col;
  logic [RowW-1:0] row_q, row_d, cur_row;
  logic            accept;
  logic            on_grid;
  logic            in_range;
  logic [dpp_pkg::DepthW-1:0] lo, hi;

  assign in_stall_o = fifo_stat_i.full;
  assign accept     = in_valid_i && !fifo_stat_i.full;

  assign cur_col = frame_start_i ? '0 : col_q;
  assign cur_row = frame_start_i ? '0 : row_q;

  always_comb begin
    if (cfg_i.mode) begin
      on_grid = (cur_col[1:0] == 2'b00) && (cur_row[1:0] == 2'b00);
      lo      = dpp_pkg::FastMinDepth;
      hi      = dpp_pkg::FastMaxDepth;
    end else begin
      on_grid = !cur_col[0] && !cur_row[0];
      lo      = cfg_i.min_depth;
      hi      = cfg_i.max_depth;
    end
  end

  assign in_range = (depth_i >= lo) && (depth_i <= hi);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (cur_col == ColW'(IMAGE_WIDTH - 1)) begin
        col_d = '0;
        row_d = (cur_row == RowW'(IMAGE_HEIGHT - 1)) ? '0 : cur_row + 1'b1;
      end else begin
        col_d = cur_col + 1'b1;
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o  = accept && on_grid && !depth_invalid_i && in_range;
  assign col_o   = cur_col;
  assign row_o   = cur_row;
  assign depth_o = depth_i;

endmodule
`default_nettype wire

// ===== rtl/dpp_fifo.sv =====
// Short queue of kept pixels between front end and projection back end.
`default_nettype none
module dpp_fifo #(
  parameter int WIDTH = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire logic [WIDTH-1:0]    wdata_i,
  input  wire logic                pop_i,
  output logic [WIDTH-1:0]         rdata_o,
  output dpp_pkg::fifo_stat_t      stat_o
);

  localparam int PtrW = (dpp_pkg::FifoDepth > 1) ? $clog2(dpp_pkg::FifoDepth) : 1;
  localparam int CntW = $clog2(dpp_pkg::FifoDepth + 1);

  logic [WIDTH-1:0] mem_q [dpp_pkg::FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(dpp_pkg::FifoDepth));
  assign stat_o.empty = (cnt_q == '0);

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(dpp_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(dpp_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== rtl/dpp_back.sv =====
// Back end: pinhole back-projection with floor shift, saturation and output register.
`default_nettype none
module dpp_back #(
  parameter int IMAGE_WIDTH  = dpp_pkg::DefImageWidth,
  parameter int IMAGE_HEIGHT = dpp_pkg::DefImageHeight,
  localparam int ColW = $clog2(IMAGE_WIDTH),
  localparam int RowW = $clog2(IMAGE_HEIGHT)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dpp_pkg::fifo_stat_t        fifo_stat_i,
  input  wire logic [ColW-1:0]            col_i,
  input  wire logic [RowW-1:0]            row_i,
  input  wire logic [dpp_pkg::DepthW-1:0] depth_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [dpp_pkg::PointW-1:0] point_x_o,
  output logic signed [dpp_pkg::PointW-1:0] point_y_o,
  output logic [dpp_pkg::DepthW-1:0]      point_z_o
);

  localparam int XOffW = ((ColW > 8) ? ColW : 8) + 1;
  localparam int YOffW = ((RowW > 8) ? RowW : 8) + 1;
  localparam int XProdW = XOffW + dpp_pkg::DepthW + 1;
  localparam int YProdW = YOffW + dpp_pkg::DepthW + 1;
  localparam int XShW = XProdW - dpp_pkg::FocalShift;
  localparam int YShW = YProdW - dpp_pkg::FocalShift;
  localparam int PW = dpp_pkg::PointW;

  localparam logic signed [XShW-1:0] XSatMax = XShW'(2 ** (PW - 1) - 1);
  localparam logic signed [XShW-1:0] XSatMin = -XShW'(2 ** (PW - 1));
  localparam logic signed [YShW-1:0] YSatMax = YShW'(2 ** (PW - 1) - 1);
  localparam logic signed [YShW-1:0] YSatMin = -YShW'(2 ** (PW - 1));

  logic signed [XOffW-1:0]  x_off;
  logic signed [YOffW-1:0]  y_off;
  logic signed [XProdW-1:0] x_prod_d, x_prod_q;
  logic signed [YProdW-1:0] y_prod_d, y_prod_q;
  logic [dpp_pkg::DepthW-1:0] z_q;
  logic                       s1_valid_q;
  logic signed [XShW-1:0]   x_sh;
  logic signed [YShW-1:0]   y_sh;
  logic signed [PW-1:0]     x_sat, y_sat;
  logic                     s1_en, s2_en;
  logic                     out_valid_q;
  logic signed [PW-1:0]     px_q, py_q;
  logic [dpp_pkg::DepthW-1:0] pz_q;

  assign s2_en = !out_valid_q || !out_stall_i;
  assign s1_en = !s1_valid_q || s2_en;
  assign pop_o = !fifo_stat_i.empty && s1_en;

  assign x_off = $signed(XOffW'(col_i)) - $signed(XOffW'(dpp_pkg::CenterX));
  assign y_off = $signed(YOffW'(row_i)) - $signed(YOffW'(dpp_pkg::CenterY));

  assign x_prod_d = x_off * $signed({1'b0, depth_i});
  assign y_prod_d = y_off * $signed({1'b0, depth_i});

  assign x_sh = x_prod_q[XProdW-1:dpp_pkg::FocalShift];
  assign y_sh = y_prod_q[YProdW-1:dpp_pkg::FocalShift];

  always_comb begin
    if (x_sh > XSatMax) begin
      x_sat = XSatMax[PW-1:0];
    end else if (x_sh < XSatMin) begin
      x_sat = XSatMin[PW-1:0];
    end else begin
      x_sat = x_sh[PW-1:0];
    end
    if (y_sh > YSatMax) begin
      y_sat = YSatMax[PW-1:0];
    end else if (y_sh < YSatMin) begin
      y_sat = YSatMin[PW-1:0];
    end else begin
      y_sat = y_sh[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= pop_o;
      end
      if (s2_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_prod_q <= x_prod_d;
      y_prod_q <= y_prod_d;
      z_q      <= depth_i;
    end
    if (s2_en && s1_valid_q) begin
      px_q <= x_sat;
      py_q <= y_sat;
      pz_q <= z_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign point_z_o   = pz_q;

endmodule
`default_nettype wire

// ===== rtl/depth_pixel_to_point_projector.sv =====
// Top level: configuration registers, front end, point queue and projection back end.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   pixel in | in_valid_i / in_stall_o | depth_i, depth_invalid_i, frame_start_i
//   point out| out_valid_o/out_stall_i | point_x_o, point_y_o, point_z_o
//   config   | APB psel/penable/pready | paddr, pwdata, pwrite, prdata
//
// One pixel transfer per cycle while the point queue has room; a kept point passes the
// queue write, the multiply register and the output register on its way out.
// The pixel side stalls only while the four-entry point queue is full.
// Reset clears the position counters, the queue and the pipeline valids and loads
// the register defaults.
`default_nettype none
module depth_pixel_to_point_projector #(
  parameter int IMAGE_WIDTH  = dpp_pkg::DefImageWidth,
  parameter int IMAGE_HEIGHT = dpp_pkg::DefImageHeight
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dpp_pkg::PaddrW-1:0]    paddr,
  input  wire logic [dpp_pkg::PdataW-1:0]    pwdata,
  output logic [dpp_pkg::PdataW-1:0]         prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [dpp_pkg::DepthW-1:0]    depth_i,
  input  wire logic                          depth_invalid_i,
  input  wire logic                          frame_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [dpp_pkg::PointW-1:0]  point_x_o,
  output logic signed [dpp_pkg::PointW-1:0]  point_y_o,
  output logic [dpp_pkg::DepthW-1:0]         point_z_o
);

  localparam int ColW = $clog2(IMAGE_WIDTH);
  localparam int RowW = $clog2(IMAGE_HEIGHT);
  localparam int EntryW = ColW + RowW + dpp_pkg::DepthW;

  dpp_pkg::cfg_t       cfg_q, cfg_d;
  dpp_pkg::fifo_stat_t fifo_stat;
  logic                cfg_wr;
  logic [1:0]          reg_idx;
  logic                push;
  logic                pop;
  logic [ColW-1:0]     front_col, back_col;
  logic [RowW-1:0]     front_row, back_row;
  logic [dpp_pkg::DepthW-1:0] front_depth, back_depth;
  logic [EntryW-1:0]   wr_entry, rd_entry;
  logic                u_front_col_next_is_one;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        dpp_pkg::RegMode:     cfg_d.mode      = pwdata[0];
        dpp_pkg::RegMinDepth: cfg_d.min_depth = pwdata[dpp_pkg::DepthW-1:0];
        dpp_pkg::RegMaxDepth: cfg_d.max_depth = pwdata[dpp_pkg::DepthW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= 1'b0;
      cfg_q.min_depth <= dpp_pkg::MinDepthRst;
      cfg_q.max_depth <= dpp_pkg::MaxDepthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      dpp_pkg::RegMode:     prdata = {{(dpp_pkg::PdataW-1){1'b0}}, cfg_q.mode};
      dpp_pkg::RegMinDepth: prdata = dpp_pkg::PdataW'(cfg_q.min_depth);
      dpp_pkg::RegMaxDepth: prdata = dpp_pkg::PdataW'(cfg_q.max_depth);
      default:              prdata = '0;
    endcase
  end

  dpp_front #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .depth_i        (depth_i),
    .depth_invalid_i(depth_invalid_i),
    .frame_start_i  (frame_start_i),
    .fifo_stat_i    (fifo_stat),
    .push_o         (push),
    .col_o          (front_col),
    .row_o          (front_row),
    .depth_o        (front_depth)
  );

  assign wr_entry = {front_col, front_row, front_depth};

  dpp_fifo #(
    .WIDTH(EntryW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(wr_entry),
    .pop_i  (pop),
    .rdata_o(rd_entry),
    .stat_o (fifo_stat)
  );

  assign {back_col, back_row, back_depth} = rd_entry;

  dpp_back #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fifo_stat_i(fifo_stat),
    .col_i      (back_col),
    .row_i      (back_row),
    .depth_i    (back_depth),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .point_x_o  (point_x_o),
    .point_y_o  (point_y_o),
    .point_z_o  (point_z_o)
  );

  assign u_front_col_next_is_one = (front_col == ColW'(1));

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_stat.full))
    else $error("point queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && fifo_stat.empty))
    else $error("point queue read while empty");

  a_frame_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && frame_start_i) |=>
      (u_front_col_next_is_one && front_row == '0) || frame_start_i)
    else $error("position counters not resynchronized by frame start");
`endif

endmodule
`default_nettype wire
